/* hw/rtl/mwe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_pkg: shared types and constants of the wireframe edge expander
// Holds the request, response and classified work types, the primitive kind
// codes and the local edge numbers.
// ----------------------------------------------------------------------------
package mwe_pkg;

   // Default depth of the queue between the front and the back (power of two).
   localparam int MWE_QUEUE_DEPTH = 2;

   // Primitive kind codes.
   localparam logic MODE_TRI  = 1'b0;
   localparam logic MODE_QUAD = 1'b1;

   // Local edge numbers within a primitive.
   localparam logic [1:0] EDGE_0 = 2'd0;
   localparam logic [1:0] EDGE_1 = 2'd1;
   localparam logic [1:0] EDGE_2 = 2'd2;
   localparam logic [1:0] EDGE_3 = 2'd3;

   // One incoming primitive.
   typedef struct packed {
      logic               mode;
      logic [30:0]        vert_a;
      logic [30:0]        vert_b;
      logic [30:0]        vert_c;
      logic [30:0]        vert_d;
      logic [29:0]        edge_base;
      logic [29:0]        edge_alt;
      logic [28:0]        face_id;
      logic [1:0]         edge_flag;
      logic signed [31:0] third_value;
      logic [29:0]        prim_number;
   } req_type;

   // One outgoing line record.
   typedef struct packed {
      logic [30:0]        line_start;
      logic [30:0]        line_end;
      logic signed [31:0] edge_id;
      logic [28:0]        face_out;
      logic [1:0]         local_edge;
      logic [29:0]        prim_out;
      logic signed [31:0] third_out;
      logic [30:0]        facing_vertex;
      logic               facing_inverted;
      logic               last;
   } rsp_type;

   // A classified primitive, as it waits in the queue.
   typedef struct packed {
      logic               quad;
      logic [30:0]        v0;
      logic [30:0]        v1;
      logic [30:0]        v2;
      logic [30:0]        v3;
      logic [31:0]        id_base;
      logic [31:0]        id_last;
      logic [28:0]        face;
      logic [29:0]        prim;
      logic signed [31:0] third;
      logic [3:0]         edge_mask;
   } work_type;

endpackage
`default_nettype wire

/* hw/rtl/mwe_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_front: request intake and classification
// Holds the refined mode register, accepts primitives while the queue has
// room and works out which edges are visible and their edge id bases.
// ----------------------------------------------------------------------------
module mwe_front
   import mwe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   input  wire logic     csr_valid,
   output logic          csr_ready,
   input  wire logic     csr_data,
   input  wire logic     q_full,
   output logic          q_push,
   output work_type      q_data
);

   logic refined_ff;
   logic refined_in;

   // The mode register takes every write; the user must write it only while idle, and the block does not enforce this.
   assign csr_ready  = 1'b1;
   assign refined_in = (csr_valid) ? csr_data : refined_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         refined_ff <= 1'b0;
      end else begin
         refined_ff <= refined_in;
      end
   end

   // A transaction enters the queue directly when there is room.
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classify the primitive: visible edges and edge id bases.
   always_comb begin
      logic flagged;
      logic mid;
      flagged = (req_data.edge_flag != 2'd0);
      mid     = refined_ff || !flagged;

      q_data.quad  = (req_data.mode == MODE_QUAD);
      q_data.v0    = req_data.vert_a;
      q_data.v1    = req_data.vert_b;
      q_data.v2    = req_data.vert_c;
      q_data.v3    = req_data.vert_d;
      q_data.face  = req_data.face_id;
      q_data.prim  = req_data.prim_number;
      q_data.third = (refined_ff) ? req_data.third_value : 32'sd0;

      // The last quad edge takes the alternate id when the flag is set.
      q_data.id_last = (flagged) ? {2'b00, req_data.edge_alt}
                                 : {2'b00, req_data.edge_base} + 32'd3;

      if (req_data.mode == MODE_TRI) begin
         // A flagged triangle shifts its ids down by one and hides edge 2 (flag bit 0), edge 0 (flag bit 1) or both.
         q_data.id_base   = (flagged) ? {2'b00, req_data.edge_base} - 32'd1
                                      : {2'b00, req_data.edge_base};
         q_data.edge_mask = {1'b0, !req_data.edge_flag[0], 1'b1,
                             !req_data.edge_flag[1]};
      end else begin
         q_data.id_base   = {2'b00, req_data.edge_base};
         q_data.edge_mask = {1'b1, mid, mid, 1'b1};
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/mwe_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_queue: classified primitive queue
// A small flop-based FIFO that decouples the front from the back. DEPTH is a
// power of two of at least two.
// ----------------------------------------------------------------------------
module mwe_queue
   import mwe_pkg::*;
#(
   parameter int DEPTH = MWE_QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output work_type      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = (push) ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = (pop)  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The queue is never pushed when full nor popped when empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

/* hw/rtl/mwe_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwe_back: line record sequencer
// Takes one classified primitive at a time and emits one line record per
// visible edge, one per cycle when not stalled, through a registered output.
// ----------------------------------------------------------------------------
module mwe_back
   import mwe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire work_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic       work_valid_ff;
   logic       work_valid_in;
   work_type   work_ff;
   work_type   work_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   logic       advance;
   logic       issue;
   logic       finishing;
   logic [1:0] pick;
   logic [3:0] rest_mask;

   // The output register can take a new record when empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign issue     = advance && work_valid_ff;
   assign finishing = issue && (rest_mask == 4'd0);
   assign q_pop     = q_valid && (!work_valid_ff || finishing);

   // Lowest visible edge goes next.
   always_comb begin
      if (work_ff.edge_mask[0]) begin
         pick = EDGE_0;
      end else if (work_ff.edge_mask[1]) begin
         pick = EDGE_1;
      end else if (work_ff.edge_mask[2]) begin
         pick = EDGE_2;
      end else begin
         pick = EDGE_3;
      end
      rest_mask = work_ff.edge_mask & ~(4'b0001 << pick);
   end

   // Build the line record for the chosen edge.
   always_comb begin
      rsp_in.edge_id    = (pick == EDGE_3) ? work_ff.id_last
                                           : work_ff.id_base + {30'd0, pick};
      rsp_in.face_out   = work_ff.face;
      rsp_in.local_edge = pick;
      rsp_in.prim_out   = work_ff.prim;
      rsp_in.third_out  = work_ff.third;
      rsp_in.last       = (rest_mask == 4'd0);
      case (pick)
         EDGE_0: begin
            rsp_in.line_start      = work_ff.v1;
            rsp_in.line_end        = work_ff.v0;
            rsp_in.facing_vertex   = work_ff.v2;
            rsp_in.facing_inverted = 1'b1;
         end
         EDGE_1: begin
            rsp_in.line_start      = work_ff.v1;
            rsp_in.line_end        = work_ff.v2;
            rsp_in.facing_vertex   = work_ff.v0;
            rsp_in.facing_inverted = 1'b0;
         end
         EDGE_2: begin
            // Triangles close back to the first corner; quads use the fourth.
            rsp_in.line_start      = (work_ff.quad) ? work_ff.v3 : work_ff.v2;
            rsp_in.line_end        = (work_ff.quad) ? work_ff.v2 : work_ff.v0;
            rsp_in.facing_vertex   = work_ff.v1;
            rsp_in.facing_inverted = work_ff.quad;
         end
         default: begin
            rsp_in.line_start      = work_ff.v3;
            rsp_in.line_end        = work_ff.v0;
            rsp_in.facing_vertex   = work_ff.v2;
            rsp_in.facing_inverted = 1'b0;
         end
      endcase
   end

   // Working primitive update: load from the queue or retire issued edges.
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (q_pop) begin
         work_in       = q_data;
         work_valid_in = 1'b1;
      end else begin
         if (issue) begin
            work_in.edge_mask = rest_mask;
         end
         if (finishing) begin
            work_valid_in = 1'b0;
         end
      end
      rsp_valid_in = (advance) ? issue : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (issue) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A held primitive always has an edge left to emit.
   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (work_ff.edge_mask != 4'd0))
      else $error("working primitive has no edge left");
   // A record not marked last keeps its primitive in the working register.
   a_keep_after_nonlast: assert property (@(posedge clock) disable iff (reset)
      (issue && !rsp_in.last) |=> work_valid_ff)
      else $error("primitive dropped before its last record");
   // A new primitive is only loaded when the previous one has finished.
   a_pop_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (q_pop && work_valid_ff) |-> (issue && rsp_in.last))
      else $error("primitive replaced before its last record");

endmodule
`default_nettype wire

/* hw/rtl/mesh_wireframe_edge_expander.sv */
`default_nettype none
// Path: a primitive's first line record passes the queue, the working primitive
// register and the output register after its request transaction is accepted;
// further records follow one per cycle while the output is not stalled.
// Throughput: a primitive gives 1 to 4 records, one for each visible edge, and
// requests flow into the queue while it has room, decoupled from the sequencer.
// Reset: synchronous; clears the refined mode register, queue and valid state.
// ----------------------------------------------------------------------------
// mesh_wireframe_edge_expander: wireframe line record generator
// Expands triangle and triangulated quad primitives into one line record per
// visible edge, with the final record of each primitive marked.
// ----------------------------------------------------------------------------
module mesh_wireframe_edge_expander
   import mwe_pkg::*;
#(
   parameter int QUEUE_DEPTH = MWE_QUEUE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic     q_full;
   logic     q_push;
   work_type q_push_data;
   logic     q_pop;
   logic     q_valid;
   work_type q_head;

   // Intake and classification.
   mwe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // Queue between intake and record sequencing.
   mwe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // Record sequencing and output register.
   mwe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* tb/sv/mesh_wireframe_edge_expander_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_wireframe_edge_expander_tb: self-checking bench of the edge expander
// Sends triangle and quad primitives under both settings of the refined mode
// register and checks every line record against typed-in or predicted records.
// A short directed table covers the edge flags, the field extremes and the
// negative edge id. Random primitives follow, with random gaps and stalls on
// both channels.
// ----------------------------------------------------------------------------
module mesh_wireframe_edge_expander_tb
   import mwe_pkg::*;
();

   // Field maxima.
   localparam logic [30:0] VERT_MAX  = 31'h7FFF_FFFF;
   localparam logic [29:0] EBASE_MAX = 30'h3FFF_FFFF;
   localparam logic [28:0] FACE_MAX  = 29'h1FFF_FFFF;
   localparam logic [29:0] PRIM_MAX  = 30'h3FFF_FFFF;

   // Edge flag codes: bit 0 hides triangle edge 2, bit 1 hides triangle edge 0.
   localparam logic [1:0] FLAG_NONE      = 2'd0;
   localparam logic [1:0] FLAG_HIDE_2    = 2'd1;
   localparam logic [1:0] FLAG_HIDE_0    = 2'd2;
   localparam logic [1:0] FLAG_HIDE_BOTH = 2'd3;

   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 74;
   localparam int LONG_HOLD_AT    = 600;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_GUARD     = 5000;

   // One row of directed stimulus, with typed-in line records where n_typed > 0.
   typedef struct {
      logic          refined;
      req_type       prim;
      int            n_typed;
      rsp_type [3:0] typed;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   rsp_type      pending_lines [$];
   stim_row_type directed_rows [$];
   logic         refined_now  = 1'b0;
   int           send_calm    = 0;
   int           mismatch_count = 0;
   int           lines_checked  = 0;
   int           prims_sent     = 0;
   int           quads_sent     = 0;
   int           mode_writes    = 0;

   mesh_wireframe_edge_expander u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Pick a wait length; now and then a calm stretch with no waits at all.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 32);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Append one expected line record to the scoreboard.
   function automatic void book_line(input rsp_type r);
      pending_lines.insert(pending_lines.size(), r);
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic req_type mk_prim(input logic mode, input logic [30:0] a,
                                       input logic [30:0] b, input logic [30:0] c,
                                       input logic [30:0] d, input logic [29:0] base,
                                       input logic [29:0] alt, input logic [28:0] face,
                                       input logic [1:0] flag, input logic [31:0] third,
                                       input logic [29:0] prim);
      req_type p;
      p.mode        = mode;
      p.vert_a      = a;
      p.vert_b      = b;
      p.vert_c      = c;
      p.vert_d      = d;
      p.edge_base   = base;
      p.edge_alt    = alt;
      p.face_id     = face;
      p.edge_flag   = flag;
      p.third_value = third;
      p.prim_number = prim;
      return p;
   endfunction

   function automatic rsp_type mk_line(input logic [30:0] start, input logic [30:0] stop,
                                       input logic [31:0] id, input logic [28:0] face,
                                       input logic [1:0] le, input logic [29:0] prim,
                                       input logic [31:0] third, input logic [30:0] fv,
                                       input logic inv, input logic last);
      rsp_type r;
      r.line_start      = start;
      r.line_end        = stop;
      r.edge_id         = id;
      r.face_out        = face;
      r.local_edge      = le;
      r.prim_out        = prim;
      r.third_out       = third;
      r.facing_vertex   = fv;
      r.facing_inverted = inv;
      r.last            = last;
      return r;
   endfunction

   // Expand one primitive into its visible edges and queue the line records.
   function automatic void expand_primitive(input req_type p, input logic refined);
      rsp_type     recs [4];
      int          n;
      logic [31:0] base;
      logic [31:0] id0;
      logic [31:0] third;
      logic        last_edge;
      n     = 0;
      base  = {2'b00, p.edge_base};
      third = refined ? p.third_value : 32'd0;
      if (p.mode == MODE_TRI) begin
         // A flagged triangle shifts all its edge ids down by one.
         id0 = base - ((p.edge_flag != FLAG_NONE) ? 32'd1 : 32'd0);
         if (!p.edge_flag[1])
            recs[n++] = mk_line(p.vert_b, p.vert_a, id0, p.face_id, EDGE_0,
                                p.prim_number, third, p.vert_c, 1'b1, 1'b0);
         recs[n++] = mk_line(p.vert_b, p.vert_c, id0 + 32'd1, p.face_id, EDGE_1,
                             p.prim_number, third, p.vert_a, 1'b0, 1'b0);
         if (!p.edge_flag[0])
            recs[n++] = mk_line(p.vert_c, p.vert_a, id0 + 32'd2, p.face_id, EDGE_2,
                                p.prim_number, third, p.vert_b, 1'b0, 1'b0);
      end else begin
         recs[n++] = mk_line(p.vert_b, p.vert_a, base, p.face_id, EDGE_0,
                             p.prim_number, third, p.vert_c, 1'b1, 1'b0);
         // The diagonal pair is dropped for flagged quads of a coarse mesh.
         if (refined || p.edge_flag == FLAG_NONE) begin
            recs[n++] = mk_line(p.vert_b, p.vert_c, base + 32'd1, p.face_id, EDGE_1,
                                p.prim_number, third, p.vert_a, 1'b0, 1'b0);
            recs[n++] = mk_line(p.vert_d, p.vert_c, base + 32'd2, p.face_id, EDGE_2,
                                p.prim_number, third, p.vert_b, 1'b1, 1'b0);
         end
         recs[n++] = mk_line(p.vert_d, p.vert_a,
                             (p.edge_flag != FLAG_NONE) ? {2'b00, p.edge_alt} : base + 32'd3,
                             p.face_id, EDGE_3, p.prim_number, third, p.vert_c,
                             1'b0, 1'b0);
      end
      for (int k = 0; k < n; k++) begin
         last_edge    = (k == n - 1);
         recs[k].last = last_edge;
         book_line(recs[k]);
      end
   endfunction

   // Random word under a mask, with the extremes drawn now and then.
   function automatic logic [31:0] pick_word(input logic [31:0] ones);
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return ones;
         default: return $urandom() & ones;
      endcase
   endfunction

   function automatic req_type random_primitive();
      logic [29:0] base;
      if ($urandom_range(0, 3) == 0)
         base = 30'($urandom_range(0, 2));
      else
         base = 30'(pick_word({2'b00, EBASE_MAX}));
      return mk_prim(1'($urandom_range(0, 1)), 31'(pick_word({1'b0, VERT_MAX})),
                     31'(pick_word({1'b0, VERT_MAX})), 31'(pick_word({1'b0, VERT_MAX})),
                     31'(pick_word({1'b0, VERT_MAX})), base,
                     30'(pick_word({2'b00, EBASE_MAX})),
                     29'(pick_word({3'b000, FACE_MAX})), 2'($urandom_range(0, 3)),
                     pick_word(32'hFFFF_FFFF), 30'(pick_word({2'b00, PRIM_MAX})));
   endfunction

   task automatic build_directed_rows();
      stim_row_type row;
      row.n_typed = 0;
      row.typed   = '0;

      // Plain triangle right after reset: coarse, so the third value is zeroed.
      row.refined  = 1'b0;
      row.prim     = mk_prim(MODE_TRI, 31'd1, 31'd2, 31'd3, 31'd4, 30'd10, 30'd0, 29'd5,
                             FLAG_NONE, 32'h0000_1234, 30'd7);
      row.n_typed  = 3;
      row.typed[0] = mk_line(31'd2, 31'd1, 32'd10, 29'd5, EDGE_0, 30'd7, 32'd0, 31'd3,
                             1'b1, 1'b0);
      row.typed[1] = mk_line(31'd2, 31'd3, 32'd11, 29'd5, EDGE_1, 30'd7, 32'd0, 31'd1,
                             1'b0, 1'b0);
      row.typed[2] = mk_line(31'd3, 31'd1, 32'd12, 29'd5, EDGE_2, 30'd7, 32'd0, 31'd2,
                             1'b0, 1'b1);
      add_row(row);

      // Edge id below zero: base 0 with a flagged triangle.
      row.prim     = mk_prim(MODE_TRI, 31'd10, 31'd20, 31'd30, 31'd40, 30'd0, 30'd0, 29'd1,
                             FLAG_HIDE_2, 32'hFFFF_FFFF, 30'd1);
      row.n_typed  = 2;
      row.typed[0] = mk_line(31'd20, 31'd10, 32'hFFFF_FFFF, 29'd1, EDGE_0, 30'd1, 32'd0,
                             31'd30, 1'b1, 1'b0);
      row.typed[1] = mk_line(31'd20, 31'd30, 32'd0, 29'd1, EDGE_1, 30'd1, 32'd0, 31'd10,
                             1'b0, 1'b1);
      add_row(row);

      // Flagged coarse quad: outer edges only, last id from the alternate field.
      row.prim     = mk_prim(MODE_QUAD, 31'd100, 31'd101, 31'd102, 31'd103, EBASE_MAX,
                             30'd12345, FACE_MAX, FLAG_HIDE_0, 32'd5, PRIM_MAX);
      row.n_typed  = 2;
      row.typed[0] = mk_line(31'd101, 31'd100, {2'b00, EBASE_MAX}, FACE_MAX, EDGE_0,
                             PRIM_MAX, 32'd0, 31'd102, 1'b1, 1'b0);
      row.typed[1] = mk_line(31'd103, 31'd100, 32'd12345, FACE_MAX, EDGE_3, PRIM_MAX,
                             32'd0, 31'd102, 1'b0, 1'b1);
      add_row(row);

      // The rest goes through the predictor.
      row.n_typed = 0;
      row.prim = mk_prim(MODE_TRI, 31'd5, 31'd6, 31'd7, 31'd8, 30'd0, 30'd0, 29'd2,
                         FLAG_HIDE_0, 32'd9, 30'd2);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, 31'd5, 31'd6, 31'd7, 31'd8, 30'd0, 30'd0, 29'd3,
                         FLAG_HIDE_BOTH, 32'd9, 30'd3);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, 31'd1, 31'd2, 31'd3, 31'd4, EBASE_MAX, 30'd0, 29'd4,
                         FLAG_NONE, 32'd1, 30'd4);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, 31'd1, 31'd2, 31'd3, 31'd4, 30'd20, 30'd99, 29'd4,
                         FLAG_HIDE_2, 32'd1, 30'd5);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, 31'd1, 31'd2, 31'd3, 31'd4, 30'd20, EBASE_MAX, 29'd4,
                         FLAG_HIDE_BOTH, 32'd1, 30'd6);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, VERT_MAX, VERT_MAX, VERT_MAX, VERT_MAX, EBASE_MAX,
                         EBASE_MAX, FACE_MAX, FLAG_NONE, 32'h7FFF_FFFF, PRIM_MAX);
      add_row(row);
      // Unused corner: vert_d differs from the first row but must not matter.
      row.prim = mk_prim(MODE_TRI, 31'd1, 31'd2, 31'd3, VERT_MAX, 30'd10, 30'd0, 29'd5,
                         FLAG_NONE, 32'h0000_1234, 30'd7);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, '0, '0, '0, '0, '0, '0, '0, FLAG_NONE, '0, '0);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, VERT_MAX, VERT_MAX, VERT_MAX, VERT_MAX, EBASE_MAX,
                         EBASE_MAX, FACE_MAX, FLAG_HIDE_BOTH, 32'hFFFF_FFFF, PRIM_MAX);
      add_row(row);

      // Refined mesh: quads keep every edge and the third value passes through.
      row.refined = 1'b1;
      row.prim = mk_prim(MODE_QUAD, VERT_MAX, VERT_MAX, VERT_MAX, VERT_MAX, EBASE_MAX,
                         EBASE_MAX, FACE_MAX, FLAG_HIDE_BOTH, 32'hFFFF_FFFF, PRIM_MAX);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, 31'd11, 31'd12, 31'd13, 31'd14, 30'd40, 30'd77,
                         29'd8, FLAG_NONE, 32'h8000_0000, 30'd9);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, 31'd21, 31'd22, 31'd23, 31'd24, 30'd50, 30'd0, 29'd9,
                         FLAG_NONE, 32'h8000_0000, 30'd10);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, 31'd21, 31'd22, 31'd23, 31'd24, 30'd0, 30'd0, 29'd9,
                         FLAG_HIDE_2, 32'h7FFF_FFFF, 30'd11);
      add_row(row);
      row.prim = mk_prim(MODE_QUAD, '0, '0, '0, '0, '0, EBASE_MAX, '0, FLAG_HIDE_0, '0,
                         '0);
      add_row(row);
      row.prim = mk_prim(MODE_TRI, 31'd3, 31'd2, 31'd1, 31'd0, EBASE_MAX, 30'd0, 29'd1,
                         FLAG_HIDE_0, 32'd42, 30'd12);
      add_row(row);
   endtask

   // Offer one primitive and book its line records once it is accepted.
   task automatic offer_primitive(input stim_row_type row);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= row.prim;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (row.n_typed > 0) begin
         for (int k = 0; k < row.n_typed; k++)
            book_line(row.typed[k]);
      end else begin
         expand_primitive(row.prim, refined_now);
      end
      prims_sent++;
      if (row.prim.mode == MODE_QUAD)
         quads_sent++;
   endtask

   // Stop sending and wait until every booked line record has come back.
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_lines.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_refined_mode(input logic value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      refined_now = value;
      mode_writes++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each accepted line record with the oldest booked one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lines.size() == 0) begin
            $display("%0t: line record with nothing expected, got 0x%h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_lines.pop_front();
            check_field("line_start", 32'(want.line_start), 32'(rsp_data.line_start));
            check_field("line_end", 32'(want.line_end), 32'(rsp_data.line_end));
            check_field("edge_id", want.edge_id, rsp_data.edge_id);
            check_field("face_out", 32'(want.face_out), 32'(rsp_data.face_out));
            check_field("local_edge", 32'(want.local_edge), 32'(rsp_data.local_edge));
            check_field("prim_out", 32'(want.prim_out), 32'(rsp_data.prim_out));
            check_field("third_out", want.third_out, rsp_data.third_out);
            check_field("facing_vertex", 32'(want.facing_vertex),
                        32'(rsp_data.facing_vertex));
            check_field("facing_inverted", 32'(want.facing_inverted),
                        32'(rsp_data.facing_inverted));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
            lines_checked++;
         end
      end
   end

   // Line record sink: random stalls, plus one long hold-off that backs up the block.
   initial begin : line_sink
      int hold;
      int taken;
      int calm;
      taken = 0;
      calm  = 0;
      @(negedge reset);
      forever begin
         hold = (taken == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(calm);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Main sequence: directed table, then random phases under both modes.
   initial begin : stimulus
      stim_row_type row;
      build_directed_rows();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].refined !== refined_now) begin
            wait_for_drain();
            write_refined_mode(directed_rows[i].refined);
         end
         offer_primitive(directed_rows[i]);
      end

      row.n_typed = 0;
      row.typed   = '0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         write_refined_mode(phase[0]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Once, hold back mid-phase until every record is home.
            if (phase == 2 && i == PHASE_ITEMS / 2)
               wait_for_drain();
            row.refined = refined_now;
            row.prim    = random_primitive();
            offer_primitive(row);
         end
      end

      wait_for_drain();
      if (pending_lines.size() != 0) begin
         $display("%0t: %0d line records never arrived", $time, pending_lines.size());
         mismatch_count += pending_lines.size();
      end
      $display("Covered %0d primitives (%0d quads), %0d line records checked,",
               prims_sent, quads_sent, lines_checked);
      $display("with %0d refined mode writes and %0d mismatches.", mode_writes,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #1000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mwe_pkg.sv
hw/rtl/mwe_front.sv
hw/rtl/mwe_queue.sv
hw/rtl/mwe_back.sv
hw/rtl/mesh_wireframe_edge_expander.sv
tb/sv/mesh_wireframe_edge_expander_tb.sv
